// ===== rtl/core/ssl_pkg.sv =====
// Package for the servo slew limiter: transaction structs, operation codes and constants.
// Used by ssl_queue, ssl_step and servo_slew_limiter_with_queue. No dependencies.
package ssl_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_QUEUE = 2'd2;

  localparam logic [1:0] RATE_ADDR = 2'd0;

  localparam logic [7:0]  HOME_ANGLE = 8'd90;
  localparam logic [7:0]  MAX_ANGLE  = 8'd180;
  localparam logic [7:0]  MAX_STEP   = 8'd255;
  localparam logic [15:0] RATE_RESET = 16'd256;
  localparam int unsigned QCOUNT_W   = 4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  angle;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          current_angle;
    logic                moving;
    logic                drive_enabled;
    logic [QCOUNT_W-1:0] queue_count;
    logic                dropped;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  function automatic logic [7:0] clamp_angle(input logic [7:0] a);
    return (a > MAX_ANGLE) ? MAX_ANGLE : a;
  endfunction

endpackage

// ===== rtl/core/ssl_queue.sv =====
// Target angle queue: one synchronous memory with head/tail pointers and a fill count.
// Depends on ssl_pkg for the push/pop control struct.
module ssl_queue #(
  parameter int unsigned Depth = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ssl_pkg::queue_ctrl_t        ctrl_i,
  input  logic [7:0]                  wdata_i,
  output logic [7:0]                  rdata_o,
  output logic [$clog2(Depth+1)-1:0]  count_o,
  output logic                        full_o,
  output logic                        empty_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  logic [7:0]      mem [Depth];
  logic [7:0]      rdata_q;
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= wdata_i;
    end
    rdata_q <= mem[head_q];
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      tail_d = (tail_q == LastIdx) ? '0 : tail_q + IdxW'(1);
    end
    if (ctrl_i.pop) begin
      head_d = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
    end
    if (ctrl_i.push && !ctrl_i.pop) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign rdata_o = rdata_q;
  assign count_o = count_q;
  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);

endmodule

// ===== rtl/core/ssl_step.sv =====
// Slew step unit: registered elapsed-times-rate product, saturated, then position update.
// Depends on ssl_pkg for the step limit.
module ssl_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mul_en_i,
  input  logic [31:0] elapsed_i,
  input  logic [15:0] rate_i,
  input  logic [7:0]  position_i,
  input  logic [7:0]  goal_i,
  output logic [7:0]  next_pos_o
);

  logic [47:0] product;
  logic [7:0]  step_q, step_d;
  logic [8:0]  sum;
  logic [7:0]  diff;

  assign product = {16'd0, elapsed_i} * {32'd0, rate_i};
  assign step_d  = (|product[47:16]) ? ssl_pkg::MAX_STEP : product[15:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (mul_en_i) begin
      step_q <= step_d;
    end
  end

  assign sum  = {1'b0, position_i} + {1'b0, step_q};
  assign diff = position_i - goal_i;

  always_comb begin
    if (position_i < goal_i) begin
      next_pos_o = (sum > {1'b0, goal_i}) ? goal_i : sum[7:0];
    end else if (position_i > goal_i) begin
      next_pos_o = (step_q >= diff) ? goal_i : position_i - step_q;
    end else begin
      next_pos_o = position_i;
    end
  end

endmodule

// ===== rtl/core/servo_slew_limiter_with_queue.sv =====
// Servo slew limiter top level: handshakes, APB rate register, sequencer and servo state.
// Depends on ssl_pkg, ssl_queue and ssl_step.
// Each transaction passes the queue read, the step multiply and the update, which waits
// while the previous result is still unaccepted; the result is then registered. No new
// transaction is accepted until the block has returned to idle.
// Reset: rate 1.0 deg/ms, angle and goal 90, stopped, drive released, queue empty.
// Queue memory is not cleared; only entries counted as filled are read.
module servo_slew_limiter_with_queue #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ssl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ssl_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QCntW = ssl_pkg::QCOUNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]             state_q, state_d;
  ssl_pkg::in_item_t      item_q;
  logic [7:0]             position_q, position_d;
  logic [7:0]             goal_q, goal_d;
  logic                   in_motion_q, in_motion_d;
  logic                   attached_q, attached_d;
  logic [31:0]            last_time_q, last_time_d;
  logic [15:0]            rate_q;
  logic                   out_valid_q, out_valid_d;
  ssl_pkg::out_item_t     out_q, out_d;

  ssl_pkg::queue_ctrl_t   q_ctrl;
  logic [7:0]             q_rdata;
  logic [CntW-1:0]        q_count, count_after;
  logic                   q_full, q_empty;
  logic                   start_q;
  logic [31:0]            elapsed;
  logic [7:0]             next_pos;
  logic [7:0]             ang_sat;
  logic                   in_fire, done_fire, mul_en;

  assign pready = 1'b1;
  assign prdata = (paddr == ssl_pkg::RATE_ADDR) ? {16'b0, rate_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= ssl_pkg::RATE_RESET;
    end else if (psel && penable && pwrite) begin
      rate_q <= pwdata[15:0];
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign done_fire   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign mul_en      = (state_q == S_MUL);
  assign start_q     = (item_q.operation == ssl_pkg::OP_TICK) && !in_motion_q && !q_empty;
  assign elapsed     = start_q ? 32'd0 : item_q.time_ms - last_time_q;
  assign ang_sat     = ssl_pkg::clamp_angle(item_q.angle);

  ssl_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (q_ctrl),
    .wdata_i (ang_sat),
    .rdata_o (q_rdata),
    .count_o (q_count),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ssl_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mul_en_i   (mul_en),
    .elapsed_i  (elapsed),
    .rate_i     (rate_q),
    .position_i (position_q),
    .goal_i     (goal_q),
    .next_pos_o (next_pos)
  );

  always_comb begin
    state_d     = state_q;
    position_d  = position_q;
    goal_d      = goal_q;
    in_motion_d = in_motion_q;
    attached_d  = attached_q;
    last_time_d = last_time_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    q_ctrl      = '0;
    count_after = q_count;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_DONE;
        if (start_q) begin
          q_ctrl.pop  = 1'b1;
          goal_d      = q_rdata;
          in_motion_d = 1'b1;
          attached_d  = 1'b1;
          last_time_d = item_q.time_ms;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          state_d       = S_IDLE;
          out_valid_d   = 1'b1;
          out_d.dropped = 1'b0;
          unique case (item_q.operation)
            ssl_pkg::OP_SET: begin
              goal_d      = ang_sat;
              in_motion_d = 1'b1;
              attached_d  = 1'b1;
              last_time_d = item_q.time_ms;
            end
            ssl_pkg::OP_QUEUE: begin
              if (q_full) begin
                out_d.dropped = 1'b1;
              end else begin
                q_ctrl.push = 1'b1;
                count_after = q_count + CntW'(1);
              end
            end
            ssl_pkg::OP_TICK: begin
              if (in_motion_q) begin
                position_d  = next_pos;
                last_time_d = item_q.time_ms;
                if (next_pos == goal_q) begin
                  in_motion_d = 1'b0;
                  attached_d  = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
          out_d.current_angle = position_d;
          out_d.moving        = in_motion_d;
          out_d.drive_enabled = attached_d;
          out_d.queue_count   = QCntW'(count_after);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      position_q  <= ssl_pkg::HOME_ANGLE;
      goal_q      <= ssl_pkg::HOME_ANGLE;
      in_motion_q <= 1'b0;
      attached_q  <= 1'b0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      position_q  <= position_d;
      goal_q      <= goal_d;
      in_motion_q <= in_motion_d;
      attached_q  <= attached_d;
      last_time_q <= last_time_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
